@@ design/btaa_pkg.sv @@
// Shared types and constants for the binary trie address allocator.
// No dependencies; every other design file except btaa_ram imports this package.
package btaa_pkg;

    localparam int ADDR_BITS  = 8;
    localparam int NODE_W     = ADDR_BITS + 1;
    localparam int TREE_DEPTH = 1 << NODE_W;
    localparam int COUNT_W    = ADDR_BITS + 1;

    // Fixed widths of the beat fields
    localparam int OPC_W  = 2;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;
    localparam int TCNT_W = 9;

    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
    localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(1) << ADDR_BITS;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NEXT   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Controller to datapath: one strobe per controller state
    typedef struct packed {
        logic clear;
        logic idle;
        logic first;
        logic up;
        logic clr;
        logic nleaf;
        logic scan;
        logic desc;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic done;
        logic go_up;
        logic go_clr;
        logic go_nleaf;
        logic go_scan;
        logic go_desc;
        logic out_free;
    } t_stat;

endpackage

@@ design/btaa_if.sv @@
// Request and response channel interfaces (valid/ready handshake).
// Depends on btaa_pkg for field widths.
interface btaa_req_if import btaa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface btaa_rsp_if import btaa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [VAL_W-1:0]  next_free;
    logic [TCNT_W-1:0] taken_count;

    modport source (output valid, output status, output found, output next_free,
                    output taken_count, input ready);
    modport sink   (input valid, input status, input found, input next_free,
                    input taken_count, output ready);
endinterface

@@ design/binary_trie_address_allocator_core.sv @@
// Top level of the binary trie address allocator.
// Depends on btaa_pkg, btaa_if, btaa_ram, btaa_ctrl and btaa_dp.
//
// Usage:
//   i_req carries one request beat: opcode (insert, remove, lookup,
//   next available) and value. o_rsp returns exactly one beat per
//   request: status, found, next_free and taken_count after the request.
//   A tree of full flags (one per node, 2^(ADDR_BITS+1) entries) lives in
//   a single-port-pair RAM; every step reads one node and writes at most one.
// Sequence:
//   After reset the tree RAM is swept to zero, one entry per cycle, over
//   all 2^(ADDR_BITS+1) entries (512 at ADDR_BITS = 8); i_req.ready stays low
//   during the sweep. One request at a time: accept step, leaf/root
//   step, then one step per tree level, then the hand-off step.
//   Lookup walks no levels; a successful insert or remove walks up to the
//   root, and next available may walk up and then down; each step of the
//   walk reads one node through the single RAM read port.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits, and its own result holds in the hand-off step until
//   the register frees up. Reset drops any pending result.
module binary_trie_address_allocator_core import btaa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btaa_req_if.sink   i_req,
    btaa_rsp_if.source o_rsp
);
    t_cmd              cmd;
    t_stat             stat;
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [NODE_W-1:0] ram_raddr;
    logic              ram_rdata;

    // Sequence the walk
    btaa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold node pointer, count and result beat
    btaa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata)
    );

    // Full flags of the tree, heap ordered
    btaa_ram #(
        .WIDTH (1),
        .DEPTH (TREE_DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule

@@ design/btaa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btaa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/btaa_ctrl.sv @@
// Sequencer for the allocator: clear sweep, tree walk steps, result hand-off.
// Depends on btaa_pkg (t_cmd, t_stat).
module btaa_ctrl import btaa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_FIRST = 9'b000000100,
        S_UP    = 9'b000001000,
        S_CLR   = 9'b000010000,
        S_NLEAF = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_DESC  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state, walk_next;

    always_comb begin
        if (i_stat.done) begin
            walk_next = S_DONE;
        end else if (i_stat.go_up) begin
            walk_next = S_UP;
        end else if (i_stat.go_clr) begin
            walk_next = S_CLR;
        end else if (i_stat.go_nleaf) begin
            walk_next = S_NLEAF;
        end else if (i_stat.go_scan) begin
            walk_next = S_SCAN;
        end else begin
            walk_next = S_DESC;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_stat.in_valid) n_state = S_FIRST;
            S_FIRST, S_UP, S_CLR, S_NLEAF, S_SCAN, S_DESC: n_state = walk_next;
            S_DONE:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.idle   = (r_state == S_IDLE);
        o_cmd.first  = (r_state == S_FIRST);
        o_cmd.up     = (r_state == S_UP);
        o_cmd.clr    = (r_state == S_CLR);
        o_cmd.nleaf  = (r_state == S_NLEAF);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.desc   = (r_state == S_DESC);
        o_cmd.finish = (r_state == S_DONE);
    end
endmodule

@@ design/btaa_dp.sv @@
// Datapath: node pointer, tree RAM port drive, count, result and output registers.
// Depends on btaa_pkg and the btaa_req_if / btaa_rsp_if interfaces.
module btaa_dp import btaa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    btaa_req_if.sink          i_req,
    btaa_rsp_if.source        o_rsp,
    output logic              o_we,
    output logic [NODE_W-1:0] o_waddr,
    output logic              o_wdata,
    output logic [NODE_W-1:0] o_raddr,
    input  logic              i_rdata
);
    t_op                  r_op, n_op;
    logic [ADDR_BITS-1:0] r_val, n_val;
    logic [NODE_W-1:0]    r_node, n_node;
    logic                 r_cur, n_cur;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_status              r_status, n_status;
    logic                 r_found, n_found;
    logic [ADDR_BITS-1:0] r_next, n_next;
    logic [NODE_W-1:0]    r_clr, n_clr;
    logic                 r_o_valid, n_o_valid;
    t_status              r_o_status;
    logic                 r_o_found;
    logic [ADDR_BITS-1:0] r_o_next;
    logic [COUNT_W-1:0]   r_o_count;

    logic [NODE_W-1:0] leaf_in, parent, sib, child;
    logic              cur, load_out;

    assign leaf_in  = LEAF_BASE | NODE_W'(ADDR_BITS'(i_req.value));
    assign parent   = r_node >> 1;
    assign sib      = r_node + NODE_W'(1);
    assign child    = {r_node[NODE_W-2:0], i_rdata};
    assign cur      = r_cur & i_rdata;
    assign load_out = i_cmd.finish && o_stat.out_free;

    always_comb begin
        n_op     = r_op;
        n_val    = r_val;
        n_node   = r_node;
        n_cur    = r_cur;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        n_next   = r_next;
        n_clr    = r_clr;
        o_we     = 1'b0;
        o_waddr  = r_node;
        o_wdata  = 1'b0;
        o_raddr  = '0;
        o_stat   = '0;
        o_stat.in_valid = i_req.valid;
        o_stat.clr_last = &r_clr;
        o_stat.out_free = !r_o_valid || o_rsp.ready;

        if (i_cmd.clear) begin
            // sweep every tree entry to zero
            o_we    = 1'b1;
            o_waddr = r_clr;
            n_clr   = r_clr + NODE_W'(1);
        end else if (i_cmd.idle) begin
            n_op     = t_op'(i_req.opcode);
            n_val    = ADDR_BITS'(i_req.value);
            n_node   = leaf_in;
            n_status = ST_OK;
            n_found  = 1'b0;
            n_next   = '0;
            o_raddr  = (t_op'(i_req.opcode) == OP_NEXT) ? ROOT_NODE : leaf_in;
        end else if (i_cmd.first) begin
            case (r_op)
                OP_INSERT: begin
                    if (i_rdata) begin
                        n_status    = ST_OCCUPIED;
                        o_stat.done = 1'b1;
                    end else begin
                        o_we         = 1'b1;
                        o_wdata      = 1'b1;
                        n_cur        = 1'b1;
                        n_count      = r_count + COUNT_W'(1);
                        o_raddr      = r_node ^ NODE_W'(1);
                        o_stat.go_up = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!i_rdata) begin
                        n_status    = ST_ABSENT;
                        o_stat.done = 1'b1;
                    end else begin
                        o_we          = 1'b1;
                        n_count       = r_count - COUNT_W'(1);
                        n_node        = parent;
                        o_stat.go_clr = 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    n_found     = i_rdata;
                    o_stat.done = 1'b1;
                end
                default: begin
                    if (i_rdata) begin
                        n_status    = ST_FULL;
                        o_stat.done = 1'b1;
                    end else begin
                        o_raddr         = r_node;
                        o_stat.go_nleaf = 1'b1;
                    end
                end
            endcase
        end else if (i_cmd.up) begin
            // parent is full when this node and its sibling are both full
            o_we    = 1'b1;
            o_waddr = parent;
            o_wdata = cur;
            n_cur   = cur;
            n_node  = parent;
            o_raddr = parent ^ NODE_W'(1);
            if (parent == ROOT_NODE) begin
                o_stat.done = 1'b1;
            end else begin
                o_stat.go_up = 1'b1;
            end
        end else if (i_cmd.clr) begin
            o_we   = 1'b1;
            n_node = parent;
            if (r_node == ROOT_NODE) begin
                o_stat.done = 1'b1;
            end else begin
                o_stat.go_clr = 1'b1;
            end
        end else if (i_cmd.nleaf) begin
            if (!i_rdata) begin
                n_next      = r_val;
                o_stat.done = 1'b1;
            end else begin
                o_raddr        = r_node ^ NODE_W'(1);
                o_stat.go_scan = 1'b1;
            end
        end else if (i_cmd.scan) begin
            if (!r_node[0] && !i_rdata) begin
                if (sib >= LEAF_BASE) begin
                    n_next      = sib[ADDR_BITS-1:0];
                    o_stat.done = 1'b1;
                end else begin
                    n_node         = sib;
                    o_raddr        = {sib[NODE_W-2:0], 1'b0};
                    o_stat.go_desc = 1'b1;
                end
            end else if (parent == ROOT_NODE) begin
                // nothing free above the start: wrap to the leftmost free leaf
                n_node         = ROOT_NODE;
                o_raddr        = ROOT_NODE << 1;
                o_stat.go_desc = 1'b1;
            end else begin
                n_node         = parent;
                o_raddr        = parent ^ NODE_W'(1);
                o_stat.go_scan = 1'b1;
            end
        end else if (i_cmd.desc) begin
            if (child >= LEAF_BASE) begin
                n_next      = child[ADDR_BITS-1:0];
                o_stat.done = 1'b1;
            end else begin
                n_node         = child;
                o_raddr        = {child[NODE_W-2:0], 1'b0};
                o_stat.go_desc = 1'b1;
            end
        end

        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_node   <= n_node;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_found  <= n_found;
        r_next   <= n_next;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_next   <= r_next;
            r_o_count  <= r_count;
        end
    end

    assign i_req.ready       = i_cmd.idle;
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.next_free   = VAL_W'(r_o_next);
    assign o_rsp.taken_count = TCNT_W'(r_o_count);

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_rsp.valid)
        else $error("result register not loaded");
    a_count_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.first |=> $stable(r_count))
        else $error("taken count moved outside the leaf step");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(LEAF_BASE))
        else $error("taken count beyond space size");
    a_desc_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.desc |-> (r_node < LEAF_BASE) && (r_node != '0))
        else $error("descent from a non-inner node");
endmodule

@@ bench/tb_checker.sv @@
// Checker for the binary trie address allocator: watches both channels,
// keeps its own occupancy map and compares every response beat.
// Depends on btaa_pkg and btaa_if.
module tb_checker import btaa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    btaa_req_if   req,
    btaa_rsp_if   rsp,
    output int    o_errors,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        logic             found;
        logic [VAL_W-1:0] next_free;
        logic [TCNT_W-1:0] taken_count;
    } t_answer;

    localparam int SPACE = 1 << ADDR_BITS;

    bit      taken_map [SPACE];
    int      taken_total;
    t_answer answer_q[$];
    int      errors;
    int      pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // Smallest free value at or above start, else the smallest overall.
    function automatic int first_free_from(input int start);
        for (int k = 0; k < SPACE; k++)
            if (!taken_map[(start + k) % SPACE]) return (start + k) % SPACE;
        return -1;
    endfunction

    function automatic t_answer apply_request(input t_op op, input logic [VAL_W-1:0] raw);
        t_answer a;
        int      v;
        int      nf;
        v = int'(raw) % SPACE;
        a = '0;
        a.status = ST_OK;
        case (op)
            OP_INSERT: if (taken_map[v]) a.status = ST_OCCUPIED;
                       else begin taken_map[v] = 1'b1; taken_total++; end
            OP_REMOVE: if (!taken_map[v]) a.status = ST_ABSENT;
                       else begin taken_map[v] = 1'b0; taken_total--; end
            OP_LOOKUP: a.found = taken_map[v];
            default: begin
                nf = first_free_from(v);
                if (nf < 0) a.status = ST_FULL;
                else a.next_free = VAL_W'(nf);
            end
        endcase
        a.taken_count = TCNT_W'(taken_total);
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (taken_map[i]) taken_map[i] = 1'b0;
            taken_total = 0;
            answer_q.delete();
            errors = errors;
        end else begin
            if (req.valid && req.ready)
                answer_q.push_back(apply_request(t_op'(req.opcode), req.value));
            if (rsp.valid && rsp.ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = answer_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.found !== want.found)
                        report_mismatch("found", rsp.found, want.found);
                    if (rsp.next_free !== want.next_free)
                        report_mismatch("next_free", rsp.next_free, want.next_free);
                    if (rsp.taken_count !== want.taken_count)
                        report_mismatch("taken_count", rsp.taken_count, want.taken_count);
                end
            end
        end
        pending = answer_q.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
    end
endmodule

@@ bench/tb_top.sv @@
// Top of the allocator testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on btaa_pkg, btaa_if,
// tb_checker and the binary_trie_address_allocator_core RTL.
module tb_top import btaa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;

    // Idle odds in percent, per phase
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   recv_hold;   // long receiver stall while requests keep coming

    btaa_req_if req ();
    btaa_rsp_if rsp ();

    binary_trie_address_allocator_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    tb_checker chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req      (req),
        .rsp      (rsp),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: drop ready at random, or hold it low for a stretch.
    always @(negedge i_clk) begin
        if (recv_hold) rsp.ready <= 1'b0;
        else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one request beat and wait for its handshake; the falling edge
    // after acceptance drops valid before the next beat starts.
    task automatic send_beat(input t_op op, input logic [VAL_W-1:0] v);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.value  <= v;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        @(negedge i_clk);
        req.valid <= 1'b0;
    endtask

    // Hold the sender until every outstanding response has come back.
    task automatic drain_responses();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random content with values drawn evenly from the whole space; fill_pct
    // sets the insert share so that the tree fills, empties and wraps.
    task automatic random_beats(input int count, input int fill_pct);
        t_op             op;
        logic [VAL_W-1:0] v;
        int              r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < fill_pct) op = OP_INSERT;
            else if (r < fill_pct + 20) op = OP_REMOVE;
            else if (r < fill_pct + 35) op = OP_LOOKUP;
            else op = OP_NEXT;
            if ($urandom_range(3) == 0) v = VAL_W'($urandom);
            else v = VAL_W'($urandom_range(31)) | (VAL_W'($urandom_range(7)) << 5);
            send_beat(op, v);
        end
    endtask

    initial begin
        int hold_cycles;
        req.valid     = 1'b0;
        req.opcode    = OP_LOOKUP;
        req.value     = '0;
        rsp.ready     = 1'b0;
        recv_hold     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-space cases, extremes, every opcode.
        send_beat(OP_REMOVE, 8'h00);     // remove of a free value
        send_beat(OP_NEXT,   8'hFF);     // free start returns itself
        send_beat(OP_INSERT, 8'h00);
        send_beat(OP_INSERT, 8'hFF);
        send_beat(OP_INSERT, 8'h00);     // already occupied
        send_beat(OP_LOOKUP, 8'h00);
        send_beat(OP_LOOKUP, 8'h7F);
        send_beat(OP_NEXT,   8'h00);     // skip over a taken leaf
        send_beat(OP_NEXT,   8'hFF);     // wrap to the lowest free value
        send_beat(OP_INSERT, 8'hAA);
        send_beat(OP_INSERT, 8'h55);
        send_beat(OP_REMOVE, 8'hFF);
        send_beat(OP_REMOVE, 8'hFF);
        send_beat(OP_LOOKUP, 8'hAA);
        drain_responses();

        // Fill the whole space, then probe the full cases and empty it.
        for (int k = 0; k < 256; k++) send_beat(OP_INSERT, VAL_W'(k));
        send_beat(OP_NEXT, 8'h80);       // space full
        send_beat(OP_INSERT, 8'h42);
        send_beat(OP_REMOVE, 8'hC3);
        send_beat(OP_NEXT, 8'hC4);       // wraps to the only hole
        send_beat(OP_NEXT, 8'h00);
        for (int k = 255; k >= 0; k--) send_beat(OP_REMOVE, VAL_W'(k));
        drain_responses();

        // Random phases: receiver idles more, then sender idles more, then neither.
        send_idle_pct = 27; recv_idle_pct = 56;
        random_beats(200, 45);
        // Long receiver stall while requests keep coming.
        fork
            begin
                @(negedge i_clk) recv_hold = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 200) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
                recv_hold = 1'b0;
            end
            random_beats(20, 40);
        join
        drain_responses();
        random_beats(200, 25);
        send_idle_pct = 56; recv_idle_pct = 27;
        random_beats(300, 55);
        drain_responses();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_beats(400, 60);
        random_beats(300, 10);

        drain_responses();
        repeat (50) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
